/* rtl/core/assert_macros.svh */
// Assertion macros used by the accumulator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define SGAA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define SGAA_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/sgaa_pkg.sv */
// Types, constants and floating-point helper functions of the accumulator.
package sgaa_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = LANES * 32;
    localparam int SUM_W      = 51;
    localparam int K_W        = 12;
    localparam int SH_W       = 7;
    localparam int EXP_W      = 10;

    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [LANES-1:0][15:0] weight;
        logic [31:0]            predictor;
        logic [31:0]            scale;
        logic [7:0]             column_group;
        logic [1:0]             batch_index;
        logic                   command;
    } item_t;

    typedef struct packed {
        logic load_item;
        logic clear_wr;
        logic mem_rd;
        logic issue;
        logic mem_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic skip;
        logic clear_last;
        logic issue_last;
        logic add_done;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [EXP_W-1:0] er;
        logic [SH_W-1:0]  sh;
    } norm_plan_t;

    typedef struct packed {
        logic [23:0] kept;
        logic        guard;
        logic        sticky;
    } norm_bits_t;

    function automatic logic f32_is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Position of the most significant set bit.
    function automatic logic [5:0] msb_pos(input logic [SUM_W-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // The value is v * 2^k; picks the result exponent and the alignment shift.
    function automatic norm_plan_t norm_plan(input logic [5:0] p,
                                             input logic signed [K_W-1:0] k);
        logic signed [K_W-1:0] eb;
        logic signed [K_W-1:0] er;
        logic signed [K_W-1:0] sh;
        norm_plan_t            r;
        eb = $signed({6'b0, p}) + k + 12'sd127;
        er = (eb < 12'sd1) ? 12'sd1 : eb;
        sh = er - 12'sd127 - k;
        if (sh > 12'sd75)
        begin
            sh = 12'sd75;
        end
        r.er = er[EXP_W-1:0];
        r.sh = sh[SH_W-1:0];
        return r;
    endfunction

    function automatic norm_bits_t norm_shift(input logic [SUM_W-1:0] v,
                                              input logic [SH_W-1:0] sh);
        logic [SUM_W+23:0] w;
        logic [SUM_W+23:0] f;
        norm_bits_t        r;
        w        = {v, 24'b0};
        f        = w >> sh;
        r.kept   = f[24:1];
        r.guard  = f[0];
        r.sticky = ((f << sh) != w);
        return r;
    endfunction

    // Round to nearest even and pack into an fp32 pattern.
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic [EXP_W-1:0] er,
                                               input norm_bits_t nb);
        logic             inc;
        logic [24:0]      m;
        logic [EXP_W-1:0] e;
        logic [31:0]      r;
        inc = nb.guard & (nb.sticky | nb.kept[0]);
        m   = {1'b0, nb.kept} + {24'b0, inc};
        if (m[24])
        begin
            e = er + 10'd1;
        end
        else if (m[23])
        begin
            e = er;
        end
        else
        begin
            e = '0;
        end
        if (e >= 10'd255)
        begin
            r = {sign, 8'hFF, 23'b0};
        end
        else
        begin
            r = {sign, e[7:0], m[22:0]};
        end
        return r;
    endfunction

endpackage

/* rtl/core/sparse_gated_axpy_accumulator_top.sv */
// Top level of the sparse gated fp16-weight AXPY accumulator.
// After reset the block clears BATCH * EMBED_SIZE / 4 accumulator entries, one per cycle,
// and takes no request until that pass is done.
// A read request reads the accumulator memory, then loads the output register once that
// register is free; only then can the next request be taken.
// An accumulate request runs a memory read, four lanes through the shared 4-stage
// multiplier and 5-stage adder, then the write back. A skipped request is dropped while idle.
module sparse_gated_axpy_accumulator_top #(
    parameter int EMBED_SIZE = 1024,
    parameter int BATCH      = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // batch_index, column_group, scale, predictor, weight_lane0..weight_lane3
    input  logic [sgaa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // sum_lane0, sum_lane1, sum_lane2, sum_lane3
    output logic [sgaa_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sgaa_pkg::*;

    item_t in_item;
    cmd_t  cmd;
    stat_t stat;

    always_comb
    begin
        in_item.command      = s_axis_tuser[0];
        in_item.batch_index  = s_axis_tdata[1:0];
        in_item.column_group = s_axis_tdata[9:2];
        in_item.scale        = s_axis_tdata[41:10];
        in_item.predictor    = s_axis_tdata[73:42];
        for (int l = 0; l < LANES; l++)
        begin
            in_item.weight[l] = s_axis_tdata[74 + 16 * l +: 16];
        end
    end

    sgaa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgaa_dp #(
        .EMBED_SIZE (EMBED_SIZE),
        .BATCH      (BATCH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/core/sgaa_fmul.sv */
// Four-stage fp32 by fp16 multiplier with an fp32 result, round to nearest even.
module sgaa_fmul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sgaa_pkg::LANE_W-1:0] in_lane,
    input  logic [31:0]                a,
    input  logic [15:0]                h,
    output logic                       out_valid,
    output logic [sgaa_pkg::LANE_W-1:0] out_lane,
    output logic [31:0]                res
);
    import sgaa_pkg::*;

    logic                  nan_a, inf_a, zero_a, nan_h, inf_h, zero_h, sign;
    logic [7:0]            ea_eff;
    logic [4:0]            eh_eff;
    logic [23:0]           ma;
    logic [10:0]           mh;
    logic [34:0]           prod;
    logic [31:0]           spec_val;
    logic signed [K_W-1:0] k;

    logic [3:0]            vld_reg;
    logic [LANE_W-1:0]     lane1_reg, lane2_reg, lane3_reg, lane4_reg;
    logic                  sign1_reg, sign2_reg, sign3_reg;
    logic                  spec1_reg, spec2_reg, spec3_reg;
    logic [31:0]           sval1_reg, sval2_reg, sval3_reg, res_reg;
    logic [SUM_W-1:0]      v1_reg, v2_reg;
    logic signed [K_W-1:0] k1_reg;
    norm_plan_t            plan2_reg;
    logic [EXP_W-1:0]      er3_reg;
    norm_bits_t            nb3_reg;

    always_comb
    begin
        nan_a  = f32_is_nan(a);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        nan_h  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        inf_h  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        zero_h = (h[14:0] == 15'd0);
        sign   = a[31] ^ h[15];
        ea_eff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eh_eff = (h[14:10] == 5'd0) ? 5'd1 : h[14:10];
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mh     = {h[14:10] != 5'd0, h[9:0]};
        prod   = {11'b0, ma} * {24'b0, mh};
        k      = $signed({4'b0, ea_eff}) + $signed({7'b0, eh_eff}) - 12'sd175;
        if (nan_a || nan_h || (inf_a && zero_h) || (inf_h && zero_a))
        begin
            spec_val = QNAN;
        end
        else if (inf_a || inf_h)
        begin
            spec_val = {sign, 8'hFF, 23'b0};
        end
        else
        begin
            spec_val = {sign, 31'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        lane1_reg <= in_lane;
        sign1_reg <= sign;
        spec1_reg <= nan_a | nan_h | inf_a | inf_h | zero_a | zero_h;
        sval1_reg <= spec_val;
        v1_reg    <= {16'b0, prod};
        k1_reg    <= k;

        lane2_reg <= lane1_reg;
        sign2_reg <= sign1_reg;
        spec2_reg <= spec1_reg;
        sval2_reg <= sval1_reg;
        v2_reg    <= v1_reg;
        plan2_reg <= norm_plan(msb_pos(v1_reg), k1_reg);

        lane3_reg <= lane2_reg;
        sign3_reg <= sign2_reg;
        spec3_reg <= spec2_reg;
        sval3_reg <= sval2_reg;
        er3_reg   <= plan2_reg.er;
        nb3_reg   <= norm_shift(v2_reg, plan2_reg.sh);

        lane4_reg <= lane3_reg;
        res_reg   <= spec3_reg ? sval3_reg : round_pack(sign3_reg, er3_reg, nb3_reg);
    end

    assign out_valid = vld_reg[3];
    assign out_lane  = lane4_reg;
    assign res       = res_reg;

endmodule

/* rtl/core/sgaa_fadd.sv */
// Five-stage fp32 adder, round to nearest even, NaN results made canonical.
module sgaa_fadd (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sgaa_pkg::LANE_W-1:0] in_lane,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    output logic                       out_valid,
    output logic [sgaa_pkg::LANE_W-1:0] out_lane,
    output logic [31:0]                res
);
    import sgaa_pkg::*;

    logic                  nan_any, inf_a, inf_b, swap;
    logic [31:0]           x, y, spec_val;
    logic [7:0]            exe, eye, d;
    logic [23:0]           mx, my;
    logic [49:0]           yfull, yal;
    logic                  lost;
    logic [SUM_W-1:0]      sum;

    logic [4:0]            vld_reg;
    logic [LANE_W-1:0]     lane1_reg, lane2_reg, lane3_reg, lane4_reg, lane5_reg;
    logic                  sign1_reg, sign2_reg, sign3_reg, sign4_reg;
    logic                  spec1_reg, spec2_reg, spec3_reg, spec4_reg;
    logic [31:0]           sval1_reg, sval2_reg, sval3_reg, sval4_reg, res_reg;
    logic                  sub1_reg, zs1_reg;
    logic [SUM_W-1:0]      xw1_reg, yw1_reg, v2_reg, v3_reg;
    logic signed [K_W-1:0] k1_reg, k2_reg;
    norm_plan_t            plan3_reg;
    logic [EXP_W-1:0]      er4_reg;
    norm_bits_t            nb4_reg;

    always_comb
    begin
        nan_any = f32_is_nan(a) || f32_is_nan(b);
        inf_a   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        swap    = (b[30:0] > a[30:0]);
        x       = swap ? b : a;
        y       = swap ? a : b;
        exe     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        eye     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx      = {x[30:23] != 8'd0, x[22:0]};
        my      = {y[30:23] != 8'd0, y[22:0]};
        d       = exe - eye;
        yfull   = {my, 26'b0};
        if (d >= 8'd50)
        begin
            yal  = '0;
            lost = (my != 24'd0);
        end
        else
        begin
            yal  = yfull >> d;
            lost = ((yal << d) != yfull);
        end
        if (nan_any || (inf_a && inf_b && (a[31] != b[31])))
        begin
            spec_val = QNAN;
        end
        else if (inf_a)
        begin
            spec_val = a;
        end
        else
        begin
            spec_val = b;
        end
        sum = sub1_reg ? (xw1_reg - yw1_reg) : (xw1_reg + yw1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        lane1_reg <= in_lane;
        sign1_reg <= x[31];
        spec1_reg <= nan_any | inf_a | inf_b;
        sval1_reg <= spec_val;
        sub1_reg  <= x[31] ^ y[31];
        zs1_reg   <= x[31] & y[31];
        xw1_reg   <= {1'b0, mx, 26'b0};
        yw1_reg   <= {1'b0, yal[49:1], yal[0] | lost};
        k1_reg    <= $signed({4'b0, exe}) - 12'sd176;

        lane2_reg <= lane1_reg;
        sign2_reg <= sign1_reg;
        spec2_reg <= spec1_reg || (sum == '0);
        sval2_reg <= spec1_reg ? sval1_reg : {zs1_reg, 31'b0};
        v2_reg    <= sum;
        k2_reg    <= k1_reg;

        lane3_reg <= lane2_reg;
        sign3_reg <= sign2_reg;
        spec3_reg <= spec2_reg;
        sval3_reg <= sval2_reg;
        v3_reg    <= v2_reg;
        plan3_reg <= norm_plan(msb_pos(v2_reg), k2_reg);

        lane4_reg <= lane3_reg;
        sign4_reg <= sign3_reg;
        spec4_reg <= spec3_reg;
        sval4_reg <= sval3_reg;
        er4_reg   <= plan3_reg.er;
        nb4_reg   <= norm_shift(v3_reg, plan3_reg.sh);

        lane5_reg <= lane4_reg;
        res_reg   <= spec4_reg ? sval4_reg : round_pack(sign4_reg, er4_reg, nb4_reg);
    end

    assign out_valid = vld_reg[4];
    assign out_lane  = lane5_reg;
    assign res       = res_reg;

endmodule

/* rtl/core/sgaa_dp.sv */
// Datapath: item register, accumulator memory, arithmetic units and output register.
module sgaa_dp #(
    parameter int EMBED_SIZE = 1024,
    parameter int BATCH      = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sgaa_pkg::cmd_t                   cmd,
    output sgaa_pkg::stat_t                  stat,
    input  sgaa_pkg::item_t                  in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sgaa_pkg::OUT_DATA_W-1:0]  out_data
);
    import sgaa_pkg::*;

    localparam int GROUPS  = EMBED_SIZE / LANES;
    localparam int ENTRIES = BATCH * GROUPS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [OUT_DATA_W-1:0]   mem [ENTRIES];

    item_t                   item_reg;
    logic                    ok_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic [LANE_W-1:0]       lane_reg;
    logic [LANES-1:0][31:0]  rdata_reg;
    logic [LANES-1:0][31:0]  sum_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_valid_reg;

    logic                    in_ok;
    logic                    pred_neg;
    logic [ADDR_W-1:0]       addr;
    logic                    mul_valid, add_valid;
    logic [LANE_W-1:0]       mul_lane, add_lane;
    logic [31:0]             mul_res, add_res;

    assign in_ok = (32'(in_item.batch_index) < 32'(BATCH)) &&
                   (32'(in_item.column_group) < 32'(GROUPS));
    assign pred_neg = in_item.predictor[31] && (in_item.predictor[30:0] != 31'd0) &&
                      !f32_is_nan(in_item.predictor);
    assign addr = ADDR_W'(32'(item_reg.batch_index) * 32'(GROUPS) +
                          32'(item_reg.column_group));

    always_comb
    begin
        stat.is_read    = (in_item.command == CMD_READ);
        stat.skip       = (in_item.command == CMD_ACC) && (!in_ok || pred_neg);
        stat.clear_last = (clr_cnt_reg == ADDR_W'(ENTRIES - 1));
        stat.issue_last = (lane_reg == LANE_W'(LANES - 1));
        stat.add_done   = add_valid && (add_lane == LANE_W'(LANES - 1));
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load_item)
            begin
                lane_reg <= '0;
            end
            else if (cmd.issue)
            begin
                lane_reg <= lane_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
            ok_reg   <= in_ok;
        end
        if (add_valid)
        begin
            sum_reg[add_lane] <= add_res;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= ok_reg ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.mem_wr)
        begin
            mem[addr] <= sum_reg;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    sgaa_fmul u_fmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.issue),
        .in_lane   (lane_reg),
        .a         (item_reg.scale),
        .h         (item_reg.weight[lane_reg]),
        .out_valid (mul_valid),
        .out_lane  (mul_lane),
        .res       (mul_res)
    );

    sgaa_fadd u_fadd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_lane   (mul_lane),
        .a         (rdata_reg[mul_lane]),
        .b         (mul_res),
        .out_valid (add_valid),
        .out_lane  (add_lane),
        .res       (add_res)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/sgaa_ctrl.sv */
// Controller state machine that sequences clearing, reads and accumulate requests.
`include "assert_macros.svh"

module sgaa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sgaa_pkg::stat_t stat,
    output sgaa_pkg::cmd_t  cmd
);
    import sgaa_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_CALC  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_WR    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       read_reg, read_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        read_next  = read_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    read_next     = stat.is_read;
                    if (!stat.skip)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (!read_reg)
                begin
                    state_next = ST_CALC;
                end
                else if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CALC:
            begin
                cmd.issue = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.add_done)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            read_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            read_reg  <= read_next;
        end
    end

    `SGAA_ASSERT(a_read_goes_to_mem, (in_valid && in_ready && stat.is_read) |=> (state_reg == ST_RD), "read request did not start a memory read")
    `SGAA_ASSERT(a_add_done_in_drain, stat.add_done |-> (state_reg == ST_DRAIN), "adder finished outside the drain state")
    `SGAA_NEVER(a_write_without_drain, cmd.mem_wr && ($past(state_reg) != ST_DRAIN), "accumulator written without a completed drain")

endmodule

/* bench/sparse_gated_axpy_accumulator_top_test.sv */
// Self-checking testbench of the sparse gated AXPY accumulator top level.
`timescale 1ns / 100ps

module sparse_gated_axpy_accumulator_top_test;

    import sgaa_pkg::*;

    typedef struct packed {
        logic [31:0] sum3;
        logic [31:0] sum2;
        logic [31:0] sum1;
        logic [31:0] sum0;
    } sums_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    item_t       request_queue[$];
    item_t       current_request;
    sums_t       expected_sums[$];
    logic [31:0] acc_store[1024][4];
    logic        idle_enable;
    logic        failed;
    int          cycle_count;

    sparse_gated_axpy_accumulator_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic is_nan32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Rounds mag * 2^ex to fp32 with round to nearest even.
    function automatic logic [31:0] round_to_single(input logic s, input logic [127:0] mag,
                                                    input int ex);
        int           p;
        int           sh;
        int           q;
        logic [127:0] m;
        logic [127:0] rest;
        logic         g;
        if (mag == 0)
        begin
            return {s, 31'b0};
        end
        p = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (mag[i])
            begin
                p = i;
            end
        end
        sh = p - 23;
        if (-149 - ex > sh)
        begin
            sh = -149 - ex;
        end
        if (sh <= 0)
        begin
            m = mag << (-sh);
        end
        else
        begin
            m = mag >> sh;
            g = mag[sh-1];
            rest = mag & ((128'd1 << (sh - 1)) - 128'd1);
            if (g && ((rest != 0) || m[0]))
            begin
                m = m + 128'd1;
            end
        end
        q = ex + sh;
        if (m[24])
        begin
            m = m >> 1;
            q++;
        end
        if (m[23])
        begin
            if (q + 150 >= 255)
            begin
                return {s, 8'hFF, 23'b0};
            end
            return {s, 8'(q + 150), m[22:0]};
        end
        return {s, 8'h00, m[22:0]};
    endfunction

    function automatic logic [31:0] scaled_weight(input logic [15:0] w, input logic [31:0] a);
        logic         w_inf;
        logic         a_inf;
        logic         w_zero;
        logic         a_zero;
        logic         s;
        logic [127:0] mw;
        logic [127:0] ma;
        int           ew;
        int           ea;
        s = w[15] ^ a[31];
        w_inf = (w[14:10] == 5'h1F) && (w[9:0] == 0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 0);
        w_zero = (w[14:0] == 0);
        a_zero = (a[30:0] == 0);
        if (((w[14:10] == 5'h1F) && !w_inf) || is_nan32(a) || (w_inf && a_zero)
            || (a_inf && w_zero))
        begin
            return QNAN;
        end
        if (w_inf || a_inf)
        begin
            return {s, 8'hFF, 23'b0};
        end
        mw = (w[14:10] == 0) ? w[9:0] : {1'b1, w[9:0]};
        ew = (w[14:10] == 0) ? -24 : int'(w[14:10]) - 25;
        ma = (a[30:23] == 0) ? a[22:0] : {1'b1, a[22:0]};
        ea = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
        return round_to_single(s, mw * ma, ew + ea);
    endfunction

    function automatic logic [31:0] single_sum(input logic [31:0] x, input logic [31:0] y);
        logic [31:0]  t;
        logic [127:0] mx;
        logic [127:0] my;
        int           ex;
        int           ey;
        int           d;
        if (is_nan32(x) || is_nan32(y))
        begin
            return QNAN;
        end
        if (x[30:23] == 8'hFF && y[30:23] == 8'hFF)
        begin
            return (x[31] == y[31]) ? x : QNAN;
        end
        if (x[30:23] == 8'hFF)
        begin
            return x;
        end
        if (y[30:23] == 8'hFF)
        begin
            return y;
        end
        if (x[30:0] == 0 && y[30:0] == 0)
        begin
            return {x[31] & y[31], 31'b0};
        end
        if (y[30:0] == 0)
        begin
            return x;
        end
        if (x[30:0] == 0)
        begin
            return y;
        end
        if (y[30:0] > x[30:0])
        begin
            t = x;
            x = y;
            y = t;
        end
        mx = (x[30:23] == 0) ? x[22:0] : {1'b1, x[22:0]};
        ex = (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
        my = (y[30:23] == 0) ? y[22:0] : {1'b1, y[22:0]};
        ey = (y[30:23] == 0) ? -149 : int'(y[30:23]) - 150;
        d = ex - ey;
        if (d > 60)
        begin
            my = 1;
            d = 62;
        end
        mx = mx << d;
        if (x[31] == y[31])
        begin
            return round_to_single(x[31], mx + my, ex - d);
        end
        if (mx == my)
        begin
            return 32'h0;
        end
        return round_to_single(x[31], mx - my, ex - d);
    endfunction

    task automatic apply_request(input item_t r);
        int    entry;
        sums_t s;
        logic  skip;
        entry = int'(r.batch_index) * 256 + int'(r.column_group);
        if (r.command == CMD_READ)
        begin
            s.sum0 = acc_store[entry][0];
            s.sum1 = acc_store[entry][1];
            s.sum2 = acc_store[entry][2];
            s.sum3 = acc_store[entry][3];
            expected_sums.push_back(s);
            return;
        end
        skip = r.predictor[31] && (r.predictor[30:0] != 0) && !is_nan32(r.predictor);
        if (skip)
        begin
            return;
        end
        for (int l = 0; l < 4; l++)
        begin
            acc_store[entry][l] = single_sum(acc_store[entry][l],
                                             scaled_weight(r.weight[l], r.scale));
        end
    endtask

    function automatic item_t make_request(input logic cmd, input logic [1:0] b,
                                           input logic [7:0] g, input logic [31:0] a,
                                           input logic [31:0] p, input logic [63:0] w);
        item_t r;
        r.command = cmd;
        r.batch_index = b;
        r.column_group = g;
        r.scale = a;
        r.predictor = p;
        r.weight = w;
        return r;
    endfunction

    function automatic logic [31:0] moderate_single();
        return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endfunction

    function automatic logic [15:0] moderate_half();
        return {1'($urandom), 5'($urandom_range(1, 30)), 10'($urandom)};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(current_request);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (request_queue.size() > 0 && !(idle_enable && $urandom_range(99) < 32))
                begin
                    current_request <= request_queue[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= request_queue[0].command;
                    s_axis_tdata <= {6'b0, request_queue[0].weight, request_queue[0].predictor,
                                     request_queue[0].scale, request_queue[0].column_group,
                                     request_queue[0].batch_index};
                    void'(request_queue.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: result expected none actual %h", $realtime, m_axis_tdata);
                    failed = 1'b1;
                end
                else
                begin
                    if (m_axis_tdata != expected_sums[0])
                    begin
                        for (int l = 0; l < 4; l++)
                        begin
                            if (m_axis_tdata[32*l +: 32] != expected_sums[0][32*l +: 32])
                            begin
                                $display("%0t: sum_lane%0d expected %h actual %h", $realtime,
                                         l, expected_sums[0][32*l +: 32],
                                         m_axis_tdata[32*l +: 32]);
                            end
                        end
                        failed = 1'b1;
                    end
                    void'(expected_sums.pop_front());
                end
            end
            m_axis_tready <= !(idle_enable && $urandom_range(99) < 32);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] half_edges[8];
        logic [31:0] single_edges[6];
        logic [63:0] w;
        logic [1:0]  b;
        logic [7:0]  g;
        logic [31:0] a;
        logic [31:0] p;
        int          k;
        clk = 1'b0;
        rst_n = 1'b0;
        failed = 1'b0;
        idle_enable = 1'b1;
        cycle_count = 0;
        for (int i = 0; i < 1024; i++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                acc_store[i][l] = 32'h0;
            end
        end
        half_edges = '{16'h0000, 16'h8000, 16'h0001, 16'h7BFF, 16'h7C00, 16'hFC00,
                       16'h7E01, 16'hFFFF};
        single_edges = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7F7F_FFFF,
                         32'h7F80_0000, 32'h7FC0_0001};
        request_queue.push_back(make_request(CMD_READ, 2'd3, 8'd255, '1, '1, '1));
        request_queue.push_back(make_request(CMD_READ, 2'd0, 8'd0, '0, '0, '0));
        for (int i = 0; i < 6; i++)
        begin
            w = {half_edges[(i + 3) % 8], half_edges[(i + 2) % 8], half_edges[i + 1],
                 half_edges[i]};
            request_queue.push_back(make_request(CMD_ACC, 2'(i % 4), 8'(i), single_edges[i],
                                                 32'h3F80_0000, w));
        end
        request_queue.push_back(make_request(CMD_ACC, 2'd1, 8'd9, 32'h3F80_0000, 32'h8000_0000,
                                             {16'h3C00, 16'h0400, 16'h03FF, 16'hBC00}));
        request_queue.push_back(make_request(CMD_ACC, 2'd1, 8'd9, 32'h4000_0000, 32'hFFC0_0000,
                                             {16'h3C00, 16'h0400, 16'h03FF, 16'hBC00}));
        request_queue.push_back(make_request(CMD_ACC, 2'd1, 8'd9, 32'h4000_0000, 32'hFF80_0000,
                                             {16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00}));
        request_queue.push_back(make_request(CMD_ACC, 2'd1, 8'd9, 32'h4000_0000, 32'hBF80_0000,
                                             {16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00}));
        request_queue.push_back(make_request(CMD_ACC, 2'd1, 8'd9, 32'h4000_0000, 32'h8000_0001,
                                             {16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00}));
        request_queue.push_back(make_request(CMD_ACC, 2'd1, 8'd9, 32'h8000_0001, 32'h0,
                                             {16'h8001, 16'h0001, 16'h7BFF, 16'hFBFF}));
        for (int i = 0; i < 6; i++)
        begin
            request_queue.push_back(make_request(CMD_READ, 2'(i % 4), 8'(i), '0, '0, '0));
        end
        request_queue.push_back(make_request(CMD_READ, 2'd1, 8'd9, '0, '0, '0));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 1450; i++)
        begin
            k = $urandom_range(99);
            b = (k < 85) ? 2'($urandom_range(1)) : 2'($urandom);
            g = (k < 85) ? 8'($urandom_range(3)) : 8'($urandom);
            if (k < 75)
            begin
                a = moderate_single();
                w = {moderate_half(), moderate_half(), moderate_half(), moderate_half()};
            end
            else
            begin
                a = $urandom;
                w = {$urandom, $urandom};
            end
            p = ($urandom_range(9) < 7) ? {1'b0, 31'($urandom)} : $urandom;
            request_queue.push_back(make_request(($urandom_range(99) < 30) ? CMD_READ : CMD_ACC,
                                                 b, g, a, p, w));
            if (i == 500)
            begin
                wait (request_queue.size() == 0);
                idle_enable = 1'b0;
            end
            if (i == 800)
            begin
                wait (request_queue.size() == 0);
                idle_enable = 1'b1;
            end
        end
        @(negedge clk);
        while (request_queue.size() != 0 || s_axis_tvalid || expected_sums.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(posedge clk);
        if (!failed && expected_sums.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
